// ----- design/sgpd_pkg.sv -----
package sgpd_pkg;

	localparam int STORE_CAPACITY = 1024;
	localparam int ADDR_W = $clog2(STORE_CAPACITY);
	localparam int COUNT_W = 11;
	localparam int COORD_BITS = 16;
	localparam int ENTRY_W = 3 * COORD_BITS;
	localparam int MAG_W = COORD_BITS;
	localparam int SQ_W = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int SLOPE_W = 16;
	localparam int DIST_W = 32;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_SLOPE_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_DIST_SQ = 2'd1;

	localparam logic [SLOPE_W-1:0] SLOPE_THRESHOLD_RESET = 16'd19661;
	localparam logic [DIST_W-1:0] MIN_DIST_SQ_RESET = 32'd409600;

	localparam logic [COUNT_W-1:0] CAPACITY_COUNT = COUNT_W'(STORE_CAPACITY);

	typedef struct packed {
		logic busy;
		logic close_valid;
		logic close;
	} dist_status_t;

endpackage

// ----- design/sgpd_dist.sv -----
module sgpd_dist (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  entry_valid,
	input  logic [sgpd_pkg::ENTRY_W-1:0]          entry,
	input  logic signed [sgpd_pkg::COORD_BITS-1:0] cand_x,
	input  logic signed [sgpd_pkg::COORD_BITS-1:0] cand_y,
	input  logic signed [sgpd_pkg::COORD_BITS-1:0] cand_z,
	input  logic [sgpd_pkg::DIST_W-1:0]           min_dist_sq,
	output sgpd_pkg::dist_status_t                status
);

	localparam int CB = sgpd_pkg::COORD_BITS;

	logic signed [CB:0] dx, dy, dz;
	logic [sgpd_pkg::MAG_W-1:0] mag_x_s2, mag_y_s2, mag_z_s2;
	logic [sgpd_pkg::SQ_W-1:0] sq_x_s3, sq_y_s3, sq_z_s3;
	logic [sgpd_pkg::SUM_W-1:0] sum;
	logic close_s4;
	logic valid_s2, valid_s3, valid_s4;

	function automatic logic [sgpd_pkg::MAG_W-1:0] magnitude(input logic signed [CB:0] d);
		logic signed [CB:0] n;
		n = -d;
		return d[CB] ? n[sgpd_pkg::MAG_W-1:0] : d[sgpd_pkg::MAG_W-1:0];
	endfunction

	assign dx = {cand_x[CB-1], cand_x} - {entry[3*CB-1], entry[3*CB-1:2*CB]};
	assign dy = {cand_y[CB-1], cand_y} - {entry[2*CB-1], entry[2*CB-1:CB]};
	assign dz = {cand_z[CB-1], cand_z} - {entry[CB-1], entry[CB-1:0]};

	assign sum = sgpd_pkg::SUM_W'(sq_x_s3) + sgpd_pkg::SUM_W'(sq_y_s3)
		+ sgpd_pkg::SUM_W'(sq_z_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= entry_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		mag_x_s2 <= magnitude(dx);
		mag_y_s2 <= magnitude(dy);
		mag_z_s2 <= magnitude(dz);
		sq_x_s3 <= mag_x_s2 * mag_x_s2;
		sq_y_s3 <= mag_y_s2 * mag_y_s2;
		sq_z_s3 <= mag_z_s2 * mag_z_s2;
		close_s4 <= sum < sgpd_pkg::SUM_W'(min_dist_sq);
	end

	assign status.busy = valid_s2 | valid_s3 | valid_s4;
	assign status.close_valid = valid_s4;
	assign status.close = close_s4;

endmodule

// ----- design/slope_gated_poisson_disk_sampler_core.sv -----
// Slope-gated Poisson-disk sampler core.
// The candidate channel (cand_valid, cand_stall) takes one point with its slope and
// a new-set flag; the result channel (res_valid, res_stall) returns one request per
// candidate with the accept mark, the overflow mark and the point count after it.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// slope threshold (index 0) and the squared radius (index 1); it is always ready.
// A candidate whose slope passes is compared against every stored point, one point
// store read per cycle; the store holds up to 1024 points. A candidate that fails
// the slope test skips the comparison. One candidate is in work at a time; the next
// one is accepted as soon as the result has been moved to the output register, even
// if that result is still waiting. When res_stall holds the output register, a
// finished candidate waits before it is committed to the store.
// Reset empties the store, loads the default threshold and radius and drops any
// pending result. Store entries are only read below the point count, so the store
// itself needs no clearing.
module slope_gated_poisson_disk_sampler_core (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   cand_valid,
	output logic                                   cand_stall,
	input  logic                                   new_set,
	input  logic signed [sgpd_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [sgpd_pkg::COORD_BITS-1:0] point_y,
	input  logic signed [sgpd_pkg::COORD_BITS-1:0] point_z,
	input  logic [sgpd_pkg::SLOPE_W-1:0]           slope_value,

	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic                                   accepted,
	output logic                                   overflow,
	output logic [sgpd_pkg::COUNT_W-1:0]           sample_count,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sgpd_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [sgpd_pkg::DIST_W-1:0]            cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0] state_q;
	logic [sgpd_pkg::SLOPE_W-1:0] slope_thr_q;
	logic [sgpd_pkg::DIST_W-1:0] min_dist_q;
	logic [sgpd_pkg::COUNT_W-1:0] count_q;
	logic [sgpd_pkg::COUNT_W-1:0] idx_q;
	logic signed [sgpd_pkg::COORD_BITS-1:0] cx_q, cy_q, cz_q;
	logic pass_q;
	logic close_q;
	logic res_valid_q, acc_q, ovf_q;
	logic [sgpd_pkg::COUNT_W-1:0] res_count_q;

	logic [sgpd_pkg::ENTRY_W-1:0] point_store [sgpd_pkg::STORE_CAPACITY];
	logic [sgpd_pkg::ENTRY_W-1:0] rd_data_s1;
	logic rd_valid_s1;

	logic cand_take;
	logic rd_en;
	logic scan_end;
	logic drained;
	logic slot_free;
	logic decide;
	logic qualify;
	logic room;
	logic wr_en;
	sgpd_pkg::dist_status_t dist_st;

	assign cand_stall = state_q != ST_IDLE;
	assign cand_take = cand_valid && !cand_stall;
	assign cfg_ready = 1'b1;

	assign scan_end = !pass_q || idx_q == count_q;
	assign rd_en = state_q == ST_SCAN && !scan_end;
	assign drained = !rd_valid_s1 && !dist_st.busy;
	assign slot_free = !res_valid_q || !res_stall;
	assign decide = state_q == ST_DRAIN && drained && slot_free;
	assign qualify = pass_q && !close_q;
	assign room = count_q < sgpd_pkg::CAPACITY_COUNT;
	assign wr_en = decide && qualify && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_thr_q <= sgpd_pkg::SLOPE_THRESHOLD_RESET;
			min_dist_q <= sgpd_pkg::MIN_DIST_SQ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == sgpd_pkg::REG_SLOPE_THRESHOLD) begin
				slope_thr_q <= cfg_data[sgpd_pkg::SLOPE_W-1:0];
			end else if (cfg_index == sgpd_pkg::REG_MIN_DIST_SQ) begin
				min_dist_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			close_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (dist_st.close_valid && dist_st.close) begin
				close_q <= 1'b1;
			end
			if (decide) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cand_take) begin
						if (new_set) begin
							count_q <= '0;
						end
						idx_q <= '0;
						close_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (decide) begin
						if (wr_en) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cand_take) begin
			cx_q <= point_x;
			cy_q <= point_y;
			cz_q <= point_z;
			pass_q <= slope_value > slope_thr_q;
		end
		if (decide) begin
			acc_q <= qualify && room;
			ovf_q <= qualify && !room;
			res_count_q <= wr_en ? count_q + 1'b1 : count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= point_store[idx_q[sgpd_pkg::ADDR_W-1:0]];
		end
		if (wr_en) begin
			point_store[count_q[sgpd_pkg::ADDR_W-1:0]] <= {cx_q, cy_q, cz_q};
		end
	end

	sgpd_dist u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (rd_valid_s1),
		.entry       (rd_data_s1),
		.cand_x      (cx_q),
		.cand_y      (cy_q),
		.cand_z      (cz_q),
		.min_dist_sq (min_dist_q),
		.status      (dist_st)
	);

	assign res_valid = res_valid_q;
	assign accepted = acc_q;
	assign overflow = ovf_q;
	assign sample_count = res_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sgpd_pkg::CAPACITY_COUNT)
		else $error("point count above store capacity");

	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(acc_q && ovf_q))
		else $error("result marks both accepted and overflow");

	a_write_grows_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> count_q == $past(count_q) + 1'b1)
		else $error("store write did not advance the point count");

	a_no_read_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !rd_valid_s1 && !dist_st.busy)
		else $error("distance pipeline busy while idle");

endmodule
